// ===== rtl/core/bad_pkg.sv =====
// Package of shared constants and types for the box average downsampler.
package bad_pkg;
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_MAX_BLOCK = 16;
   localparam int LANES = 4;

   typedef enum logic [2:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_BLOCK_WIDTH   = 3'd2,
      CSR_BLOCK_HEIGHT  = 3'd3,
      CSR_CHANNEL_COUNT = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_DIV  = 2'd2,
      ST_OUT  = 2'd3
   } state_type;
endpackage

// ===== rtl/core/box_average_downsampler_core.sv =====
// Top level of the streaming box average downsampler.
// Pixels enter on the req_ channel in raster order, one transaction per pixel
// with four channel bytes; the csr_ port sets image and block sizes and the
// channel count; a write to a known index restarts the frame top-left.
// A transaction that completes a block produces one rsp_ transaction with the
// per-channel truncated means, the block position and an end-of-image flag.
// A pixel that closes no block passes through acceptance, at whose edge the
// block-column sum is read from RAM, and then the update; one that closes a
// block passes through acceptance, update, the four parallel bit-serial
// divider lanes, which divide sums of SW bits, the sum width (16 bits at the
// defaults), and output. The result waits in an output register; a
// stalled receiver holds the block, and new pixels, until rsp_ready is seen.
// Synchronous reset sets all sizes to 1 and the position to zero; the
// column-sum RAM needs no clearing since every band writes before it reads.
module box_average_downsampler_core
   import bad_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_chan_a,
   input  logic [7:0]  req_chan_b,
   input  logic [7:0]  req_chan_c,
   input  logic [7:0]  req_chan_d,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_avg_a,
   output logic [7:0]  rsp_avg_b,
   output logic [7:0]  rsp_avg_c,
   output logic [7:0]  rsp_avg_d,
   output logic [9:0]  rsp_out_column,
   output logic [15:0] rsp_out_row,
   output logic        rsp_last_of_image
);
   localparam int BW  = $clog2(MAX_BLOCK + 1);
   localparam int OW  = $clog2(MAX_BLOCK);
   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int SW  = 8 + 2 * OW;
   localparam int CW  = 2 * BW;
   localparam int RW  = 8 + OW;
   localparam int DIV_STEPS = SW;

   logic [10:0] img_w_ff;
   logic [15:0] img_h_ff;
   logic [4:0]  blk_w_ff, blk_h_ff;
   logic [2:0]  chn_ff;

   // Configuration registers; any valid write restarts the frame.
   logic restart;
   assign restart = csr_write && (csr_index <= CSR_CHANNEL_COUNT);
   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= 11'd1;
         img_h_ff <= 16'd1;
         blk_w_ff <= 5'd1;
         blk_h_ff <= 5'd1;
         chn_ff   <= 3'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   img_w_ff <= csr_data[10:0];
            CSR_IMAGE_HEIGHT:  img_h_ff <= csr_data;
            CSR_BLOCK_WIDTH:   blk_w_ff <= csr_data[4:0];
            CSR_BLOCK_HEIGHT:  blk_h_ff <= csr_data[4:0];
            CSR_CHANNEL_COUNT: chn_ff   <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // Clamped effective sizes.
   logic [XW:0]   w_eff;
   logic [15:0]   h_eff;
   logic [BW-1:0] bw_eff, bh_eff;
   logic [2:0]    nc_eff;
   always_comb begin
      if (img_w_ff == 11'd0) w_eff = (XW+1)'(1);
      else if ({21'd0, img_w_ff} > MAX_WIDTH) w_eff = (XW+1)'(MAX_WIDTH);
      else w_eff = (XW+1)'(img_w_ff);
      h_eff = (img_h_ff == 16'd0) ? 16'd1 : img_h_ff;
      if (blk_w_ff == 5'd0) bw_eff = BW'(1);
      else if ({27'd0, blk_w_ff} > MAX_BLOCK) bw_eff = BW'(MAX_BLOCK);
      else bw_eff = BW'(blk_w_ff);
      if (blk_h_ff == 5'd0) bh_eff = BW'(1);
      else if ({27'd0, blk_h_ff} > MAX_BLOCK) bh_eff = BW'(MAX_BLOCK);
      else bh_eff = BW'(blk_h_ff);
      if (chn_ff == 3'd0) nc_eff = 3'd1;
      else if (chn_ff > 3'd4) nc_eff = 3'd4;
      else nc_eff = chn_ff;
   end

   // Position state; block column and row kept as counters instead of divides.
   logic [XW-1:0] col_ff;
   logic [15:0]   row_ff;
   logic [OW-1:0] ox_ff, oy_ff;
   logic [XW-1:0] bc_ff;
   logic [15:0]   br_ff;
   logic [RW-1:0] rps_ff [LANES];
   logic [7:0]    pix_ff [LANES];
   state_type     st_ff, st_in;
   logic [$clog2(DIV_STEPS+1)-1:0] cnt_ff;

   logic row_end, col_end, end_x, end_y;
   assign row_end = ({1'b0, col_ff} + 1'b1) >= w_eff;
   assign col_end = ({1'b0, row_ff} + 17'd1) >= {1'b0, h_eff};
   assign end_x = row_end || ({1'b0, ox_ff} + 1'b1 >= bw_eff);
   assign end_y = col_end || ({1'b0, oy_ff} + 1'b1 >= bh_eff);

   // Column-sum RAM, one word of four lane sums per block column.
   logic              ram_we;
   logic [4*SW-1:0]   ram_wd, ram_rd;
   bad_ram #(.WIDTH(4*SW), .DEPTH(MAX_WIDTH)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(bc_ff), .wr_data(ram_wd),
      .rd_addr(bc_ff), .rd_data(ram_rd)
   );

   // Lane sums of the closing row segment and the new band sums.
   logic [RW-1:0] rps_new [LANES];
   logic [SW-1:0] band_new [LANES];
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         rps_new[l] = (ox_ff == '0) ? RW'(pix_ff[l]) : rps_ff[l] + RW'(pix_ff[l]);
         band_new[l] = (oy_ff == '0) ? SW'(rps_new[l])
                     : ram_rd[l*SW +: SW] + SW'(rps_new[l]);
         ram_wd[l*SW +: SW] = band_new[l];
      end
   end

   logic upd;
   assign upd = (st_ff == ST_READ);
   assign ram_we = upd && end_x;

   // Divider lanes and the merge into one result.
   logic [SW-1:0] divd_ff [LANES];
   logic [CW-1:0] cnt_div_ff;
   logic [7:0]    quo [LANES];
   logic          dstart;
   assign dstart = (st_ff == ST_READ) && end_x && end_y;
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      bad_lane #(.SW(SW), .CW(CW)) u_lane (
         .clock(clock), .start(dstart), .dividend(band_new[g]),
         .divisor(cnt_div_ff),
         .quotient(quo[g])
      );
   end

   logic [7:0] avg_ff [LANES];
   logic [9:0] oc_ff;
   logic [15:0] or_ff;
   logic last_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (req_valid) st_in = ST_READ;
         ST_READ: st_in = (end_x && end_y) ? ST_DIV : ST_IDLE;
         ST_DIV:  if (cnt_ff == '0) st_in = ST_OUT;
         ST_OUT:  if (rsp_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   assign req_ready = (st_ff == ST_IDLE);
   assign rsp_valid = (st_ff == ST_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
      // Capture the pixel, lanes at or beyond the channel count read as zero.
      if (req_valid && req_ready) begin
         pix_ff[0] <= req_chan_a;
         pix_ff[1] <= (nc_eff > 3'd1) ? req_chan_b : 8'd0;
         pix_ff[2] <= (nc_eff > 3'd2) ? req_chan_c : 8'd0;
         pix_ff[3] <= (nc_eff > 3'd3) ? req_chan_d : 8'd0;
      end
      // The pixel count of the block is held for the whole division.
      if (dstart) begin
         cnt_ff <= ($clog2(DIV_STEPS+1))'(DIV_STEPS);
         oc_ff <= 10'(bc_ff);
         or_ff <= br_ff;
         last_ff <= row_end && col_end;
         cnt_div_ff <= CW'({1'b0, ox_ff} + 1'b1) * CW'({1'b0, oy_ff} + 1'b1);
      end else if (st_ff == ST_DIV) begin
         if (cnt_ff == '0) begin
            for (int l = 0; l < LANES; l++) avg_ff[l] <= quo[l];
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // Position and row partial sum update after the column read.
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0; row_ff <= '0; ox_ff <= '0; oy_ff <= '0;
         bc_ff <= '0; br_ff <= '0;
         for (int l = 0; l < LANES; l++) rps_ff[l] <= '0;
      end else if (upd) begin
         for (int l = 0; l < LANES; l++) rps_ff[l] <= rps_new[l];
         if (row_end) begin
            col_ff <= '0; ox_ff <= '0; bc_ff <= '0;
            if (col_end) begin
               row_ff <= '0; oy_ff <= '0; br_ff <= '0;
            end else begin
               row_ff <= row_ff + 16'd1;
               oy_ff <= end_y ? '0 : oy_ff + 1'b1;
               if (end_y) br_ff <= br_ff + 16'd1;
            end
         end else begin
            col_ff <= col_ff + 1'b1;
            ox_ff <= end_x ? '0 : ox_ff + 1'b1;
            if (end_x) bc_ff <= bc_ff + 1'b1;
         end
      end
   end

   assign rsp_avg_a = avg_ff[0];
   assign rsp_avg_b = avg_ff[1];
   assign rsp_avg_c = avg_ff[2];
   assign rsp_avg_d = avg_ff[3];
   assign rsp_out_column = oc_ff;
   assign rsp_out_row = or_ff;
   assign rsp_last_of_image = last_ff;
endmodule

// ===== rtl/core/bad_ram.sv =====
// Generic single-port-write, registered-read RAM.
module bad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/core/bad_lane.sv =====
// One channel lane: bit-serial restoring divider of a block sum by its pixel count.
module bad_lane #(
   parameter int SW = 16,
   parameter int CW = 12
) (
   input  logic          clock,
   input  logic          start,
   input  logic [SW-1:0] dividend,
   input  logic [CW-1:0] divisor,
   output logic [7:0]    quotient
);
   logic [SW-1:0] quo_ff, quo_in;
   logic [SW:0]   rem_ff, rem_in;
   logic [SW:0]   trial;

   // One quotient bit per cycle, most significant first.
   always_comb begin
      trial = {rem_ff[SW-1:0], quo_ff[SW-1]};
      quo_in = {quo_ff[SW-2:0], 1'b0};
      rem_in = trial;
      if (trial >= {{(SW+1-CW){1'b0}}, divisor}) begin
         rem_in = trial - {{(SW+1-CW){1'b0}}, divisor};
         quo_in[0] = 1'b1;
      end
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient = quo_ff[7:0];
endmodule

// ===== rtl/core/bad_checker.sv =====
// Port-level checker for the box average downsampler, bound to the top level.
module bad_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_avg_a
);
   // A pending result blocks new pixels.
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("pixel accepted with result pending");

   // An accepted pixel is never followed at once by another acceptance.
   a_gap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("back-to-back accept");

   // A stalled result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_avg_a)))
      else $error("stalled result changed");
endmodule

bind box_average_downsampler_core bad_checker u_bad_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_avg_a(rsp_avg_a)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the box average downsampler core.
module testbench
   import bad_pkg::*;
();

   // One downsampled block as it leaves the core.
   typedef struct {
      logic [7:0]  avg_a;
      logic [7:0]  avg_b;
      logic [7:0]  avg_c;
      logic [7:0]  avg_d;
      logic [9:0]  column;
      logic [15:0] row;
      logic        last;
   } block_mean_type;

   // Scoreboard: tracks the frame position and block sums, and holds the
   // block means still owed by the core.
   class block_mean_scoreboard_type;
      int unsigned img_w, img_h, blk_w, blk_h, chans;
      int unsigned band_sums[1024][4];
      int unsigned line_sums[4];
      int unsigned px_col, px_row, in_x, in_y;
      block_mean_type owed_q[$];
      int unsigned mismatches;
      int unsigned blocks_seen;
      int unsigned frames_seen;

      function new();
         img_w = 1;
         img_h = 1;
         blk_w = 1;
         blk_h = 1;
         chans = 1;
         mismatches = 0;
         blocks_seen = 0;
         frames_seen = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         for (int c = 0; c < 4; c++) line_sums[c] = 0;
         px_col = 0;
         px_row = 0;
         in_x = 0;
         in_y = 0;
      endfunction

      function int unsigned clamp(int unsigned v, int unsigned hi);
         if (v == 0) return 1;
         return (v > hi) ? hi : v;
      endfunction

      // A register write; unknown indexes leave the frame alone.
      function void write_reg(logic [2:0] idx, logic [15:0] data);
         case (idx)
            CSR_IMAGE_WIDTH:   img_w = data[10:0];
            CSR_IMAGE_HEIGHT:  img_h = data;
            CSR_BLOCK_WIDTH:   blk_w = data[4:0];
            CSR_BLOCK_HEIGHT:  blk_h = data[4:0];
            CSR_CHANNEL_COUNT: chans = data[2:0];
            default: return;
         endcase
         restart_frame();
      endfunction

      // Accepted pixel: update the sums and queue a block mean if one closes.
      function void note_input(logic [7:0] pa, logic [7:0] pb, logic [7:0] pc,
                               logic [7:0] pd);
         int unsigned w, h, bw, bh, nc, bc, cnt, v;
         bit row_end, col_end, end_x, end_y;
         logic [7:0] px[4];
         logic [7:0] mean[4];
         block_mean_type e;
         px[0] = pa;
         px[1] = pb;
         px[2] = pc;
         px[3] = pd;
         w = clamp(img_w, 1024);
         h = clamp(img_h, 65535);
         bw = clamp(blk_w, 16);
         bh = clamp(blk_h, 16);
         nc = clamp(chans, 4);
         row_end = (px_col + 1 >= w);
         col_end = (px_row + 1 >= h);
         end_x = row_end || (in_x + 1 >= bw);
         end_y = col_end || (in_y + 1 >= bh);
         bc = (px_col / bw) % 1024;
         for (int c = 0; c < 4; c++) begin
            v = (c < nc) ? px[c] : 0;
            line_sums[c] = (in_x == 0) ? v : line_sums[c] + v;
            if (end_x) begin
               band_sums[bc][c] = (in_y == 0) ? line_sums[c]
                                              : band_sums[bc][c] + line_sums[c];
            end
         end
         if (end_x && end_y) begin
            cnt = (in_x + 1) * (in_y + 1);
            for (int c = 0; c < 4; c++) mean[c] = 8'(band_sums[bc][c] / cnt);
            e.avg_a = mean[0];
            e.avg_b = mean[1];
            e.avg_c = mean[2];
            e.avg_d = mean[3];
            e.column = 10'(px_col / bw);
            e.row = 16'(px_row / bh);
            e.last = row_end && col_end;
            owed_q.push_back(e);
         end
         if (row_end) begin
            px_col = 0;
            in_x = 0;
            if (col_end) begin
               px_row = 0;
               in_y = 0;
            end else begin
               px_row++;
               in_y = end_y ? 0 : in_y + 1;
            end
         end else begin
            px_col++;
            in_x = end_x ? 0 : in_x + 1;
         end
      endfunction

      // Compare one result transaction with the oldest owed block mean.
      function void check_result(block_mean_type got);
         block_mean_type e;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected block mean col %0d row %0d", $time,
                     got.column, got.row);
            mismatches++;
            return;
         end
         e = owed_q.pop_front();
         blocks_seen++;
         if (got.last === 1'b1) frames_seen++;
         if (got.avg_a !== e.avg_a) begin
            $display("%0t: avg_a expected %0d actual %0d", $time, e.avg_a, got.avg_a);
            mismatches++;
         end
         if (got.avg_b !== e.avg_b) begin
            $display("%0t: avg_b expected %0d actual %0d", $time, e.avg_b, got.avg_b);
            mismatches++;
         end
         if (got.avg_c !== e.avg_c) begin
            $display("%0t: avg_c expected %0d actual %0d", $time, e.avg_c, got.avg_c);
            mismatches++;
         end
         if (got.avg_d !== e.avg_d) begin
            $display("%0t: avg_d expected %0d actual %0d", $time, e.avg_d, got.avg_d);
            mismatches++;
         end
         if (got.column !== e.column) begin
            $display("%0t: out_column expected %0d actual %0d", $time, e.column,
                     got.column);
            mismatches++;
         end
         if (got.row !== e.row) begin
            $display("%0t: out_row expected %0d actual %0d", $time, e.row, got.row);
            mismatches++;
         end
         if (got.last !== e.last) begin
            $display("%0t: last_of_image expected %0d actual %0d", $time, e.last,
                     got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_chan_a;
   logic [7:0]  req_chan_b;
   logic [7:0]  req_chan_c;
   logic [7:0]  req_chan_d;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_avg_a;
   logic [7:0]  rsp_avg_b;
   logic [7:0]  rsp_avg_c;
   logic [7:0]  rsp_avg_d;
   logic [9:0]  rsp_out_column;
   logic [15:0] rsp_out_row;
   logic        rsp_last_of_image;

   block_mean_scoreboard_type sb;
   bit quiet;
   int unsigned pixels_sent;
   int unsigned settings_used;

   box_average_downsampler_core dut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_chan_a(req_chan_a),
      .req_chan_b(req_chan_b),
      .req_chan_c(req_chan_c),
      .req_chan_d(req_chan_d),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_avg_a(rsp_avg_a),
      .rsp_avg_b(rsp_avg_b),
      .rsp_avg_c(rsp_avg_c),
      .rsp_avg_d(rsp_avg_d),
      .rsp_out_column(rsp_out_column),
      .rsp_out_row(rsp_out_row),
      .rsp_last_of_image(rsp_last_of_image)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: check every accepted transaction, stall in random bursts.
   initial begin
      int unsigned stall;
      block_mean_type got;
      stall = 0;
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            got.avg_a = rsp_avg_a;
            got.avg_b = rsp_avg_b;
            got.avg_c = rsp_avg_c;
            got.avg_d = rsp_avg_d;
            got.column = rsp_out_column;
            got.row = rsp_out_row;
            got.last = rsp_last_of_image;
            sb.check_result(got);
         end
         if (stall > 0) begin
            stall--;
            if (stall == 0) rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 15);
            rsp_ready <= 1'b0;
         end
      end
   end

   // Send one pixel, optionally after an idle burst, and wait for acceptance.
   task automatic send_pixel(logic [7:0] pa, logic [7:0] pb, logic [7:0] pc,
                             logic [7:0] pd);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_chan_a <= pa;
      req_chan_b <= pb;
      req_chan_c <= pc;
      req_chan_d <= pd;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_input(pa, pb, pc, pd);
      pixels_sent++;
   endtask

   task automatic send_random_pixel();
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind == 0) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      else if (kind == 1) send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      else send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Wait until the core has delivered everything and gone quiet.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Register write, legal only while the core is drained.
   task automatic write_csr(logic [2:0] idx, logic [15:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      csr_write <= 1'b0;
   endtask

   // Full setting; spare upper data bits are filled at random.
   task automatic apply_setting(int unsigned w, int unsigned h, int unsigned bw,
                                int unsigned bh, int unsigned nc);
      logic [15:0] r;
      drain();
      r = 16'($urandom);
      write_csr(CSR_IMAGE_WIDTH, {r[15:11], w[10:0]});
      write_csr(CSR_IMAGE_HEIGHT, h[15:0]);
      r = 16'($urandom);
      write_csr(CSR_BLOCK_WIDTH, {r[15:5], bw[4:0]});
      r = 16'($urandom);
      write_csr(CSR_BLOCK_HEIGHT, {r[15:5], bh[4:0]});
      r = 16'($urandom);
      write_csr(CSR_CHANNEL_COUNT, {r[15:3], nc[2:0]});
      settings_used++;
   endtask

   function automatic int unsigned pick_block();
      int unsigned k;
      k = $urandom_range(0, 9);
      if (k == 0) return 0;
      if (k == 1) return $urandom_range(16, 31);
      return $urandom_range(1, 5);
   endfunction

   initial begin
      int unsigned w, h, n;
      sb = new();
      quiet = 1'b0;
      pixels_sent = 0;
      settings_used = 0;
      reset <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_data <= '0;
      req_valid <= 1'b0;
      req_chan_a <= '0;
      req_chan_b <= '0;
      req_chan_c <= '0;
      req_chan_d <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults after reset: every pixel is its own block.
      send_pixel(8'hFF, 8'h12, 8'h34, 8'h56);
      send_pixel(8'h00, 8'hFF, 8'hFF, 8'hFF);

      // Three by two image, two by two blocks, all channels: clipped right edge.
      apply_setting(3, 2, 2, 2, 4);
      send_pixel(8'hFF, 8'hFF, 8'h00, 8'h01);
      send_pixel(8'hFF, 8'h00, 8'hFF, 8'h02);
      send_pixel(8'h80, 8'h7F, 8'h01, 8'hFE);
      send_pixel(8'hFF, 8'h00, 8'hFF, 8'h03);
      send_pixel(8'hFE, 8'hFF, 8'h00, 8'h04);
      send_pixel(8'h81, 8'h80, 8'hAA, 8'h55);
      // The frame wraps and a second image follows with the same setting.
      repeat (6) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);

      // Zero sizes act as one; oversized channel count acts as four.
      apply_setting(0, 0, 0, 0, 7);
      send_pixel(8'hA5, 8'h5A, 8'hC3, 8'h3C);
      // Zero channel count acts as one; tall clipped bottom block.
      apply_setting(2, 3, 1, 31, 0);
      repeat (6) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);

      // Writes to unknown indexes must not disturb a frame in progress.
      apply_setting(2, 2, 2, 2, 2);
      send_pixel(8'h10, 8'h20, 8'h30, 8'h40);
      drain();
      write_csr(3'd5, 16'($urandom));
      write_csr(3'd6, 16'($urandom));
      write_csr(3'd7, 16'hFFFF);
      repeat (3) send_pixel(8'h11, 8'h22, 8'h33, 8'h44);

      // Largest block in both directions, saturating values.
      apply_setting(16, 16, 16, 16, 4);
      repeat (256) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);

      // Random settings and pixels; mostly whole frames of small images.
      n = 0;
      while (n < 300) begin
         w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40)
                                          : $urandom_range(1, 12);
         h = ($urandom_range(0, 15) == 0) ? 65535 : $urandom_range(0, 8);
         apply_setting(w, h, pick_block(), pick_block(), $urandom_range(0, 7));
         w = (w == 0) ? 1 : w;
         h = (h == 0 || h > 8) ? 8 : h;
         for (int k = $urandom_range(1, 3) * w * h; k > 0 && n < 300; k--) begin
            if (n > 240) quiet = 1'b1;
            // Hold off once until every owed block has been delivered.
            if (n == 100) begin
               req_valid <= 1'b0;
               while (sb.owed_q.size() != 0) @(posedge clock);
            end
            send_random_pixel();
            n++;
         end
      end

      drain();
      repeat (100) @(posedge clock);
      $display("Sent %0d pixels under %0d settings; %0d block means checked,",
               pixels_sent, settings_used, sb.blocks_seen);
      $display("%0d complete images, with clipped edges and random stalls.",
               sb.frames_seen);
      if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog for a core that hangs.
   initial begin
      #30000000;
      $display("Timeout with %0d block means still owed.", sb.owed_q.size());
      $display("end of test: mismatches");
      $finish;
   end
endmodule

// ===== box_average_downsampler_core.f =====
rtl/core/bad_pkg.sv
rtl/core/bad_ram.sv
rtl/core/bad_lane.sv
rtl/core/box_average_downsampler_core.sv
rtl/core/bad_checker.sv
verif/testbench.sv
